@@ design/mhms_pkg.sv @@
// shared types for the min-heap merge sorter
package mhms_pkg;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_INS_RD   = 9'b000000010,
        ST_INS_CMP  = 9'b000000100,
        ST_POP_TOP  = 9'b000001000,
        ST_POP_LAST = 9'b000010000,
        ST_POP_MOVE = 9'b000100000,
        ST_SD_L     = 9'b001000000,
        ST_SD_R     = 9'b010000000,
        ST_SD_CMP   = 9'b100000000
    } state_t;

endpackage

@@ design/min_heap_merge_sorter.sv @@
// min-heap merge sorter: pooled heap sort of signed values held in one memory
// A beat is taken when start is high and busy is low. A beat with has_value
// stores its value in a binary min-heap held in a single-port-read,
// single-port-write memory of HEAP_DEPTH entries; values arriving while the
// heap is full are dropped and flag overflow on every result of that set. A
// beat with last then drains the heap: each value comes out on value_res for
// one cycle with res_valid high, in ascending order, last_res marking the
// final one. Results cannot be held off. Each step of an insert's sift-up
// costs one memory read of the parent and one compare. Each result of a drain
// reads the root, emits it and moves the last entry to the root; each step of
// its sift-down reads the left, then the right child and compares the smaller
// with it. busy stays high from an accepted beat that stores a value or starts
// a drain until its insert and any drain are done; an empty set emits nothing.
module min_heap_merge_sorter #(
    parameter int HEAP_DEPTH = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         has_value,
    input  logic signed [VALUE_BITS-1:0] value,
    input  logic                         last,
    output logic                         res_valid,
    output logic signed [VALUE_BITS-1:0] value_res,
    output logic                         last_res,
    output logic                         overflow
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);

    mhms_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                count_reg, count_next;
    logic                         dropped_reg, dropped_next;
    logic                         last_pend_reg, last_pend_next;
    logic [AW-1:0]                pos_reg, pos_next;
    logic signed [VALUE_BITS-1:0] val_reg, val_next;
    logic signed [VALUE_BITS-1:0] left_reg, left_next;

    logic                         res_valid_reg, res_valid_next;
    logic signed [VALUE_BITS-1:0] value_res_reg, value_res_next;
    logic                         last_res_reg, last_res_next;
    logic                         overflow_reg, overflow_next;

    logic signed [VALUE_BITS-1:0] heap_mem [HEAP_DEPTH];
    logic signed [VALUE_BITS-1:0] rdata_reg;
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic signed [VALUE_BITS-1:0] mem_wdata;
    logic [AW-1:0]                mem_raddr;

    logic                         accept;
    logic                         full;
    logic [AW+1:0]                left_idx;
    logic [AW+1:0]                right_idx;
    logic [AW+1:0]                count_ext;
    logic                         left_ok;
    logic                         right_ok;
    logic [AW-1:0]                up_idx;
    logic                         take_right;
    logic signed [VALUE_BITS-1:0] child_val;
    logic [AW-1:0]                child_idx;

    assign accept    = start && !busy;
    assign busy      = (state_reg != mhms_pkg::ST_IDLE);
    assign full      = (count_reg == CW'(HEAP_DEPTH));
    assign left_idx  = {1'b0, pos_reg, 1'b1};
    assign right_idx = left_idx + (AW+2)'(1);
    assign count_ext = (AW+2)'(count_reg);
    assign left_ok   = (left_idx < count_ext);
    assign right_ok  = (right_idx < count_ext);
    assign up_idx    = AW'((pos_reg - AW'(1)) >> 1);
    assign take_right = right_ok && (rdata_reg < left_reg);
    assign child_val  = take_right ? rdata_reg : left_reg;
    assign child_idx  = take_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        last_pend_next = last_pend_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        left_next      = left_reg;
        res_valid_next = 1'b0;
        value_res_next = value_res_reg;
        last_res_next  = last_res_reg;
        overflow_next  = overflow_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg;
        mem_wdata      = val_reg;
        mem_raddr      = pos_reg;

        unique case (state_reg)
            mhms_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    last_pend_next = last;
                    if (has_value && !full)
                    begin
                        pos_next   = count_reg[AW-1:0];
                        val_next   = value;
                        count_next = count_reg + CW'(1);
                        state_next = mhms_pkg::ST_INS_RD;
                    end
                    else
                    begin
                        if (has_value)
                        begin
                            dropped_next = 1'b1;
                        end
                        if (last)
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = mhms_pkg::ST_POP_TOP;
                            end
                            else
                            begin
                                dropped_next = 1'b0;
                            end
                        end
                    end
                end
            end
            mhms_pkg::ST_INS_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    state_next = last_pend_reg ? mhms_pkg::ST_POP_TOP : mhms_pkg::ST_IDLE;
                end
                else
                begin
                    mem_raddr  = up_idx;
                    state_next = mhms_pkg::ST_INS_CMP;
                end
            end
            mhms_pkg::ST_INS_CMP:
            begin
                mem_we = 1'b1;
                if (val_reg < rdata_reg)
                begin
                    mem_wdata  = rdata_reg;
                    pos_next   = up_idx;
                    state_next = mhms_pkg::ST_INS_RD;
                end
                else
                begin
                    state_next = last_pend_reg ? mhms_pkg::ST_POP_TOP : mhms_pkg::ST_IDLE;
                end
            end
            mhms_pkg::ST_POP_TOP:
            begin
                mem_raddr  = '0;
                state_next = mhms_pkg::ST_POP_LAST;
            end
            mhms_pkg::ST_POP_LAST:
            begin
                res_valid_next = 1'b1;
                value_res_next = rdata_reg;
                last_res_next  = (count_reg == CW'(1));
                overflow_next  = dropped_reg;
                mem_raddr      = AW'(count_reg - CW'(1));
                count_next     = count_reg - CW'(1);
                state_next     = mhms_pkg::ST_POP_MOVE;
            end
            mhms_pkg::ST_POP_MOVE:
            begin
                if (count_reg == '0)
                begin
                    dropped_next = 1'b0;
                    state_next   = mhms_pkg::ST_IDLE;
                end
                else
                begin
                    pos_next   = '0;
                    val_next   = rdata_reg;
                    state_next = mhms_pkg::ST_SD_L;
                end
            end
            mhms_pkg::ST_SD_L:
            begin
                if (left_ok)
                begin
                    mem_raddr  = left_idx[AW-1:0];
                    state_next = mhms_pkg::ST_SD_R;
                end
                else
                begin
                    mem_we     = 1'b1;
                    state_next = mhms_pkg::ST_POP_TOP;
                end
            end
            mhms_pkg::ST_SD_R:
            begin
                left_next  = rdata_reg;
                mem_raddr  = right_idx[AW-1:0];
                state_next = mhms_pkg::ST_SD_CMP;
            end
            mhms_pkg::ST_SD_CMP:
            begin
                mem_we = 1'b1;
                if (child_val < val_reg)
                begin
                    mem_wdata  = child_val;
                    pos_next   = child_idx;
                    state_next = mhms_pkg::ST_SD_L;
                end
                else
                begin
                    state_next = mhms_pkg::ST_POP_TOP;
                end
            end
            default:
            begin
                state_next = mhms_pkg::ST_IDLE;
            end
        endcase
    end

    // heap storage, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heap_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= heap_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mhms_pkg::ST_IDLE;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            last_pend_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            last_pend_reg <= last_pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        left_reg      <= left_next;
        value_res_reg <= value_res_next;
        last_res_reg  <= last_res_next;
        overflow_reg  <= overflow_next;
    end

    assign res_valid = res_valid_reg;
    assign value_res = value_res_reg;
    assign last_res  = last_res_reg;
    assign overflow  = overflow_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(HEAP_DEPTH))
        else $error("heap count beyond capacity");

    a_res_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $past(state_reg == mhms_pkg::ST_POP_LAST))
        else $error("result beat outside a pop");

    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && last_res) |-> (count_reg == '0))
        else $error("final result with values still stored");

    a_busy_while_draining: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !last_res) |=> busy)
        else $error("block idle in the middle of a drain");

endmodule

@@ verif/testbench.sv @@
// testbench for min_heap_merge_sorter: table-driven and random sets checked against a sorting model
module testbench;

    localparam int DEPTH       = 64;
    localparam int VBITS       = 32;
    localparam int N_ITEMS     = 260;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_TAIL  = 64;
    localparam int N_ROWS      = 18;
    localparam int PRINT_CAP   = 50;

    localparam logic signed [VBITS-1:0] VMIN = {1'b1, {(VBITS-1){1'b0}}};
    localparam logic signed [VBITS-1:0] VMAX = {1'b0, {(VBITS-1){1'b1}}};

    typedef struct packed {
        logic signed [VBITS-1:0] val;
        logic                    fin;
        logic                    ovf;
    } sorted_t;

    typedef struct packed {
        logic                    hv;
        logic signed [VBITS-1:0] val;
        logic                    lst;
        logic                    typed;
        sorted_t                 want;
    } row_t;

    localparam row_t DIRECTED [N_ROWS] = '{
        '{1'b1, VMIN,          1'b1, 1'b1, '{VMIN, 1'b1, 1'b0}},
        '{1'b1, VMAX,          1'b1, 1'b1, '{VMAX, 1'b1, 1'b0}},
        '{1'b0, 32'sd0,        1'b1, 1'b0, '0},
        '{1'b0, 32'h5a5a_5a5a, 1'b0, 1'b0, '0},
        '{1'b1, 32'sd0,        1'b0, 1'b0, '0},
        '{1'b1, 32'hffff_ffff, 1'b0, 1'b0, '0},
        '{1'b1, VMAX,          1'b0, 1'b0, '0},
        '{1'b1, VMIN,          1'b0, 1'b0, '0},
        '{1'b1, 32'sd5,        1'b0, 1'b0, '0},
        '{1'b1, 32'sd5,        1'b0, 1'b0, '0},
        '{1'b0, 32'hffff_ffff, 1'b0, 1'b0, '0},
        '{1'b1, 32'h8000_0001, 1'b0, 1'b0, '0},
        '{1'b1, 32'h7fff_fffe, 1'b0, 1'b0, '0},
        '{1'b0, 32'sd0,        1'b1, 1'b0, '0},
        '{1'b1, 32'hffff_fff9, 1'b0, 1'b0, '0},
        '{1'b1, 32'hffff_fff9, 1'b1, 1'b0, '0},
        '{1'b0, 32'sd0,        1'b1, 1'b0, '0},
        '{1'b1, 32'sd1,        1'b1, 1'b1, '{32'sd1, 1'b1, 1'b0}}
    };

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic                    has_value;
    logic signed [VBITS-1:0] value;
    logic                    last;
    logic                    res_valid;
    logic signed [VBITS-1:0] value_res;
    logic                    last_res;
    logic                    overflow;

    // sorting model state: pool kept in ascending order
    logic signed [VBITS-1:0] pool [DEPTH];
    int                      pool_count;
    logic                    pool_dropped;
    sorted_t                 drain_q [$];
    sorted_t                 got_want;

    int   errors;
    int   beats;
    int   sets;
    int   n_results;
    int   ovf_sets;
    int   quiet;
    logic idle_on;

    min_heap_merge_sorter #(
        .HEAP_DEPTH(DEPTH),
        .VALUE_BITS(VBITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .has_value(has_value),
        .value(value),
        .last(last),
        .res_valid(res_valid),
        .value_res(value_res),
        .last_res(last_res),
        .overflow(overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report(input string msg);
        errors++;
        if (errors <= PRINT_CAP)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic pool_beat(input logic hv, input logic signed [VBITS-1:0] v,
                             input logic lst);
        int      j;
        sorted_t r;
        if (hv)
        begin
            if (pool_count < DEPTH)
            begin
                j = pool_count;
                while (j > 0 && pool[j-1] > v)
                begin
                    pool[j] = pool[j-1];
                    j--;
                end
                pool[j] = v;
                pool_count++;
            end
            else
                pool_dropped = 1'b1;
        end
        if (lst)
        begin
            for (int i = 0; i < pool_count; i++)
            begin
                r.val = pool[i];
                r.fin = (i == pool_count - 1);
                r.ovf = pool_dropped;
                drain_q.push_back(r);
            end
            pool_count   = 0;
            pool_dropped = 1'b0;
        end
    endtask

    task automatic send_beat(input logic hv, input logic signed [VBITS-1:0] v,
                             input logic lst, input logic typed, input sorted_t want);
        int n0;
        @(negedge clk);
        start     <= 1'b1;
        has_value <= hv;
        value     <= v;
        last      <= lst;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        n0 = drain_q.size();
        pool_beat(hv, v, lst);
        // typed-in rows replace what the model worked out
        if (typed)
        begin
            while (drain_q.size() > n0)
                void'(drain_q.pop_back());
            drain_q.push_back(want);
        end
        if (hv || lst)
            beats++;
        if (lst)
            sets++;
    endtask

    task automatic pause(input int n);
        @(negedge clk);
        start     <= 1'b0;
        has_value <= $urandom_range(0, 1);
        value     <= $urandom;
        last      <= $urandom_range(0, 1);
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic gap();
        if (idle_on && $urandom_range(0, 2) == 0)
            pause($urandom_range(1, 11));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (drain_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [VBITS-1:0] draw_value();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1) ? VMIN : VMAX;
            1, 2:    return $urandom_range(0, 15) - 32'd8;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_set(input int n_vals);
        logic end_marker;
        end_marker = (n_vals == 0) || ($urandom_range(0, 1) == 1);
        for (int k = 0; k < n_vals; k++)
        begin
            // stray beat carrying neither value nor last
            if ($urandom_range(0, 9) == 0)
            begin
                send_beat(1'b0, $urandom, 1'b0, 1'b0, '0);
                gap();
            end
            send_beat(1'b1, draw_value(), !end_marker && k == n_vals - 1, 1'b0, '0);
            gap();
        end
        if (end_marker)
        begin
            send_beat(1'b0, $urandom, 1'b1, 1'b0, '0);
            gap();
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || res_valid)
                quiet = 0;
            else
                quiet = quiet + 1;
            if (res_valid)
            begin
                n_results++;
                if (drain_q.size() == 0)
                    report($sformatf("result %0d with nothing pending", value_res));
                else
                begin
                    got_want = drain_q.pop_front();
                    if (value_res !== got_want.val)
                        report($sformatf("value_res %0d, want %0d", value_res, got_want.val));
                    if (last_res !== got_want.fin)
                        report($sformatf("last_res %b, want %b", last_res, got_want.fin));
                    if (overflow !== got_want.ovf)
                        report($sformatf("overflow %b, want %b", overflow, got_want.ovf));
                    if (got_want.fin && got_want.ovf)
                        ovf_sets++;
                end
            end
            if (quiet >= QUIET_LIMIT)
            begin
                $display("stalled for %0d cycles with %0d results pending", quiet,
                         drain_q.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        has_value    = 1'b0;
        value        = '0;
        last         = 1'b0;
        pool_count   = 0;
        pool_dropped = 1'b0;
        errors       = 0;
        beats        = 0;
        sets         = 0;
        n_results    = 0;
        ovf_sets     = 0;
        quiet        = 0;
        idle_on      = 1'b1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_ROWS; i++)
        begin
            send_beat(DIRECTED[i].hv, DIRECTED[i].val, DIRECTED[i].lst,
                      DIRECTED[i].typed, DIRECTED[i].want);
            gap();
        end

        // one set past capacity, one exactly full
        send_set($urandom_range(DEPTH + 1, DEPTH + 6));
        send_set(DEPTH);
        wait_drained();

        while (beats < N_ITEMS)
        begin
            idle_on = (beats < N_ITEMS - 40) && ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 15) == 0)
                send_set($urandom_range(DEPTH - 4, DEPTH + 4));
            else
                send_set($urandom_range(0, 12));
        end

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge clk);
        $display("%0d beats in %0d sets, %0d results checked, %0d sets with dropped values",
                 beats, sets, n_results, ovf_sets);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
design/mhms_pkg.sv
design/min_heap_merge_sorter.sv
verif/testbench.sv
